### rtl/dda_pkg.sv
package dda_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int MAX_SIDE   = 64;
  localparam int OUT_CAP    = 64;
  localparam int COORD_W    = 24;
  localparam int COLOR_W    = 24;
  localparam int PIX_W      = $clog2(MAX_SIDE);
  localparam int SIDE_W     = 7;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SLOPE_FRAC = 16;
  localparam int QUOT_W     = SLOPE_FRAC + 1;
  localparam int SLOPE_W    = QUOT_W + 1;
  localparam int REM_W      = DIFF_W + 1;
  localparam int DIV_CNT_W  = $clog2(QUOT_W + 1);
  localparam int STEP_W     = DIFF_W - FRAC_BITS + 1;
  localparam int PROD_W     = STEP_W + 1 + SLOPE_W;
  localparam int MAJ_W      = DIFF_W + 2;
  localparam int ACC_W      = PROD_W + 3;
  localparam int CNT_W      = $clog2(OUT_CAP + 1);
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0]        stroke_color;
  } seg_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               pixel_valid;
    logic               last_pixel;
  } pix_t;

endpackage

### rtl/dda_line_rasterizer_top.sv
// dda line rasterizer
// input: a segment transaction (two signed Q15.8 endpoints and a color) is
// taken when start is high and busy is low. busy stays high until the
// segment is fully walked; no new segment is taken meanwhile.
// output: one pixel write per out_strobe cycle; out_data.last_pixel marks
// the final write. a segment with no pixel inside the canvas gives a single
// result with pixel_valid low and last_pixel high. the receiver cannot
// stall; every strobe is a transaction.
// config: cfg_valid/cfg_ready write canvas width (index 0) or height
// (index 1); cfg_ready is always high. write only while busy is low.
// sequence: a setup state, then the slope divider (one quotient bit per
// cycle), then S_MUL and S_INIT to position the walk, then one walk step
// per major-axis step inside the canvas (at most 65) plus one that ends the
// walk, then a flush state for the final result. busy stays high from
// setup through the flush state.
// reset: canvas returns to 64 x 64, any segment in flight is dropped.
module dda_line_rasterizer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  dda_pkg::seg_t                  in_data,
  output logic                           out_strobe,
  output dda_pkg::pix_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dda_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dda_pkg::SIDE_W-1:0]     cfg_data
);
  import dda_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_INIT  = 3'd4;
  localparam logic [2:0] S_WALK  = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;

  localparam logic signed [MAJ_W-1:0] ONE = MAJ_W'(1 << FRAC_BITS);
  localparam int BASE_SH = SLOPE_FRAC - FRAC_BITS;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    return (v > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : v;
  endfunction

  logic [2:0]                state_r;
  logic [SIDE_W-1:0]         width_r;
  logic [SIDE_W-1:0]         height_r;
  seg_t                      seg_r;
  logic signed [COORD_W-1:0] m0_r;
  logic signed [COORD_W-1:0] n0_r;
  logic                      neg_r;
  logic                      minneg_r;
  logic                      xmaj_r;
  logic                      none_r;
  logic                      zero_r;
  logic [DIFF_W-1:0]         amaj_r;
  logic [SIDE_W-1:0]         majlim_r;
  logic [SIDE_W-1:0]         minlim_r;
  logic [STEP_W-1:0]         i0_r;
  logic [STEP_W-1:0]         steps_r;
  logic signed [SLOPE_W-1:0] slope_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [MAJ_W-1:0]   m_r;
  logic [STEP_W-1:0]         i_r;
  logic [CNT_W-1:0]          cnt_r;
  pix_t                      pend_r;
  logic                      out_strobe_r;
  pix_t                      out_data_r;

  logic [SIDE_W-1:0]         wc;
  logic [SIDE_W-1:0]         hc;
  logic signed [DIFF_W-1:0]  dx;
  logic signed [DIFF_W-1:0]  dy;
  logic [DIFF_W-1:0]         adx;
  logic [DIFF_W-1:0]         ady;
  logic                      xmaj;
  logic                      div_done;
  logic [QUOT_W-1:0]         div_quot;

  logic signed [MAJ_W-1:0]   m0_ext;
  logic signed [MAJ_W-1:0]   hi;
  logic signed [MAJ_W-1:0]   gap;
  logic [STEP_W-1:0]         i0;
  logic signed [MAJ_W-1:0]   moff;
  logic signed [ACC_W-1:0]   base;

  logic                      stop;
  logic                      n_ok;
  logic                      hit;
  logic [PIX_W-1:0]          mt;
  logic [PIX_W-1:0]          nt;
  pix_t                      cur;
  pix_t                      fin;

  assign wc = clamp_side(width_r);
  assign hc = clamp_side(height_r);

  assign dx   = $signed({seg_r.end_x[COORD_W-1], seg_r.end_x})
              - $signed({seg_r.start_x[COORD_W-1], seg_r.start_x});
  assign dy   = $signed({seg_r.end_y[COORD_W-1], seg_r.end_y})
              - $signed({seg_r.start_y[COORD_W-1], seg_r.start_y});
  assign adx  = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign ady  = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
  assign xmaj = (adx > ady);

  dda_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (state_r == S_SETUP),
    .num  (xmaj ? ady : adx),
    .den  (xmaj ? adx : ady),
    .done (div_done),
    .quot (div_quot)
  );

  // first step index whose major coordinate can be inside the canvas
  assign m0_ext = MAJ_W'(m0_r);
  assign hi     = $signed(MAJ_W'({majlim_r, {FRAC_BITS{1'b0}}}));
  assign gap    = neg_r ? (m0_ext - hi) : (-ONE - m0_ext);
  assign i0     = gap[MAJ_W-1] ? '0 : (STEP_W'(gap >>> FRAC_BITS) + 1'b1);
  assign moff   = $signed(MAJ_W'({i0_r, {FRAC_BITS{1'b0}}}));
  assign base   = ACC_W'(n0_r) <<< BASE_SH;

  assign stop = (i_r >= steps_r) || (m_r <= -ONE) || (m_r >= hi)
              || (cnt_r == CNT_W'(OUT_CAP));
  assign n_ok = acc_r[ACC_W-1]
              ? ((&acc_r[ACC_W-1:SLOPE_FRAC]) && (acc_r[SLOPE_FRAC-1:0] != '0))
              : (acc_r[ACC_W-1:SLOPE_FRAC] < (ACC_W - SLOPE_FRAC)'(minlim_r));
  assign hit  = !stop && n_ok;
  assign mt   = m_r[MAJ_W-1] ? '0 : m_r[FRAC_BITS +: PIX_W];
  assign nt   = acc_r[ACC_W-1] ? '0 : acc_r[SLOPE_FRAC +: PIX_W];

  always_comb begin
    cur.pixel_x     = xmaj_r ? mt : nt;
    cur.pixel_y     = xmaj_r ? nt : mt;
    cur.pixel_color = seg_r.stroke_color;
    cur.pixel_valid = 1'b1;
    cur.last_pixel  = 1'b0;
  end

  // final result: the held pixel, or an empty completion
  always_comb begin
    fin            = pend_r.pixel_valid ? pend_r : '0;
    fin.last_pixel = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIDE_W'(MAX_SIDE);
      height_r <= SIDE_W'(MAX_SIDE);
    end else if (cfg_valid) begin
      priority if (cfg_index == CFG_CANVAS_WIDTH) begin
        width_r <= cfg_data;
      end else if (cfg_index == CFG_CANVAS_HEIGHT) begin
        height_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_SETUP;
          end
        end
        S_SETUP: state_r <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state_r <= S_MUL;
          end
        end
        S_MUL:  state_r <= S_INIT;
        S_INIT: state_r <= none_r ? S_FLUSH : S_WALK;
        S_WALK: begin
          if (stop) begin
            state_r <= S_FLUSH;
          end else if (hit && pend_r.pixel_valid) begin
            out_strobe_r <= 1'b1;
          end
        end
        S_FLUSH: begin
          out_strobe_r <= 1'b1;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        seg_r <= in_data;
      end
      S_SETUP: begin
        xmaj_r   <= xmaj;
        m0_r     <= xmaj ? seg_r.start_x : seg_r.start_y;
        n0_r     <= xmaj ? seg_r.start_y : seg_r.start_x;
        neg_r    <= xmaj ? dx[DIFF_W-1] : dy[DIFF_W-1];
        minneg_r <= xmaj ? dy[DIFF_W-1] : dx[DIFF_W-1];
        amaj_r   <= xmaj ? adx : ady;
        zero_r   <= xmaj ? (adx == '0) : (ady == '0);
        majlim_r <= xmaj ? wc : hc;
        minlim_r <= xmaj ? hc : wc;
        none_r   <= (wc == '0) || (hc == '0);
      end
      S_DIV: begin
        i0_r    <= i0;
        steps_r <= STEP_W'(amaj_r >> FRAC_BITS) + 1'b1;
        if (zero_r) begin
          slope_r <= '0;
        end else if (minneg_r) begin
          slope_r <= -$signed({1'b0, div_quot});
        end else begin
          slope_r <= $signed({1'b0, div_quot});
        end
      end
      S_MUL: begin
        prod_r <= $signed({1'b0, i0_r}) * slope_r;
      end
      S_INIT: begin
        acc_r  <= base + ACC_W'(prod_r);
        m_r    <= neg_r ? (m0_ext - moff) : (m0_ext + moff);
        i_r    <= i0_r;
        cnt_r  <= '0;
        pend_r <= '0;
      end
      S_WALK: begin
        if (!stop) begin
          i_r   <= i_r + 1'b1;
          m_r   <= neg_r ? (m_r - ONE) : (m_r + ONE);
          acc_r <= acc_r + ACC_W'(slope_r);
          if (hit) begin
            out_data_r <= pend_r;
            pend_r     <= cur;
            cnt_r      <= cnt_r + 1'b1;
          end
        end
      end
      S_FLUSH: begin
        out_data_r <= fin;
      end
      default: begin
        cnt_r <= '0;
      end
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.pixel_valid |-> out_data.last_pixel)
    else $error("empty completion without last marker");

  a_last_ends_segment: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.last_pixel |-> !busy)
    else $error("last result while segment still in progress");

  a_mid_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.last_pixel |-> busy)
    else $error("non-final result outside a segment");

  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_strobe)
    else $error("segment accept not followed by setup");

  a_pixel_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.pixel_valid |->
      (SIDE_W'(out_data.pixel_x) < wc) && (SIDE_W'(out_data.pixel_y) < hc))
    else $error("pixel write outside canvas");

endmodule

### rtl/dda_div.sv
module dda_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [dda_pkg::DIFF_W-1:0]    num,
  input  logic [dda_pkg::DIFF_W-1:0]    den,
  output logic                          done,
  output logic [dda_pkg::QUOT_W-1:0]    quot
);
  import dda_pkg::*;

  logic                 active_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [REM_W-1:0]     rem_r;
  logic [REM_W-1:0]     den_r;
  logic [QUOT_W-1:0]    quot_r;
  logic [REM_W-1:0]     trial;
  logic                 ge;

  // first step compares the numerator itself, later ones shift by one
  assign trial = (cnt_r == DIV_CNT_W'(QUOT_W)) ? rem_r : {rem_r[REM_W-2:0], 1'b0};
  assign ge    = (trial >= den_r);
  assign done  = active_r && (cnt_r == '0);
  assign quot  = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else if (go) begin
      active_r <= 1'b1;
      cnt_r    <= DIV_CNT_W'(QUOT_W);
    end else if (done) begin
      active_r <= 1'b0;
    end else if (active_r) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r  <= REM_W'(num);
      den_r  <= REM_W'(den);
      quot_r <= '0;
    end else if (active_r && (cnt_r != '0)) begin
      rem_r  <= ge ? (trial - den_r) : trial;
      quot_r <= {quot_r[QUOT_W-2:0], ge};
    end
  end

endmodule
